// File: design/krt_pkg.sv
`default_nettype none
package krt_pkg;

	localparam logic [2:0] OP_PRESS   = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_TICK    = 3'd2;
	localparam logic [2:0] OP_READ    = 3'd3;
	localparam logic [2:0] OP_CLEAR   = 3'd4;

	localparam logic [1:0] CFG_START_FRAMES = 2'd0;
	localparam logic [1:0] CFG_SLOW_SPAN    = 2'd1;
	localparam logic [1:0] CFG_FAST_SPAN    = 2'd2;

	localparam logic [7:0] FL_PUSH       = 8'h01;
	localparam logic [7:0] FL_PRESS      = 8'h02;
	localparam logic [7:0] FL_PRESS_REP  = 8'h04;
	localparam logic [7:0] FL_PRESS_FAST = 8'h08;
	localparam logic [7:0] FL_PULL       = 8'h10;
	localparam logic [7:0] FL_FREE       = 8'h20;
	localparam logic [7:0] FL_FREE_REP   = 8'h40;
	localparam logic [7:0] FL_FREE_FAST  = 8'h80;

	localparam logic [7:0] FLAGS_PRESS_EVT   = FL_PUSH | FL_PRESS | FL_PRESS_REP | FL_PRESS_FAST;
	localparam logic [7:0] FLAGS_RELEASE_EVT = FL_PULL | FL_FREE | FL_FREE_REP | FL_FREE_FAST;

	localparam logic [9:0] START_FRAMES_RESET = 10'd30;
	localparam logic [7:0] SLOW_SPAN_RESET    = 8'd8;
	localparam logic [7:0] FAST_SPAN_RESET    = 8'd2;

	typedef struct packed {
		logic [7:0]  flags;
		logic [15:0] frames;
		logic [7:0]  slow;
		logic [7:0]  fast;
	} entry_t;

	typedef struct packed {
		logic [9:0] start_frames;
		logic [7:0] slow_span;
		logic [7:0] fast_span;
	} cfg_t;

	localparam entry_t ENTRY_RESET = '{flags: FL_FREE, frames: 16'd0, slow: 8'd0, fast: 8'd0};

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_RDWAIT,
		ST_TICK,
		ST_CLEAR,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

// File: design/krt_mem.sv
`default_nettype none
module krt_mem #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire krt_pkg::entry_t wdata,
	input  wire logic            re,
	input  wire logic [AW-1:0]   raddr,
	output krt_pkg::entry_t      rdata
);

	krt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: design/krt_tick_unit.sv
`default_nettype none
module krt_tick_unit (
	input  wire krt_pkg::entry_t cur,
	input  wire krt_pkg::cfg_t   cfg,
	output krt_pkg::entry_t      nxt,
	output logic                 trig
);

	logic [7:0] f;
	logic [7:0] rep;
	logic [7:0] fast;
	logic       level;

	always_comb begin
		nxt   = cur;
		trig  = 1'b0;
		f     = cur.flags;
		rep   = 8'd0;
		fast  = 8'd0;
		level = 1'b0;
		if (cur.frames != 16'd0) begin
			if ((cur.flags & krt_pkg::FL_PRESS) != 8'd0) begin
				f     = krt_pkg::FL_PRESS;
				rep   = krt_pkg::FL_PRESS_REP;
				fast  = krt_pkg::FL_PRESS_FAST;
				level = 1'b1;
			end else if ((cur.flags & krt_pkg::FL_FREE) != 8'd0) begin
				f     = krt_pkg::FL_FREE;
				rep   = krt_pkg::FL_FREE_REP;
				fast  = krt_pkg::FL_FREE_FAST;
				level = 1'b1;
			end
			if (level && (cur.frames >= {6'd0, cfg.start_frames})) begin
				if (cur.slow == 8'd0) begin
					nxt.slow = cfg.slow_span;
					f        = f | rep;
				end else begin
					nxt.slow = cur.slow - 8'd1;
				end
				if (cur.fast == 8'd0) begin
					nxt.fast = cfg.fast_span;
					f        = f | fast;
				end else begin
					nxt.fast = cur.fast - 8'd1;
				end
			end
			nxt.flags = f;
		end else begin
			trig = 1'b1;
		end
		if (cur.frames != 16'hFFFF) begin
			nxt.frames = cur.frames + 16'd1;
		end
	end

endmodule
`default_nettype wire

// File: design/key_repeat_tracker.sv
`default_nettype none
// Keyboard auto-repeat table with one entry per key, kept in a single-port-write,
// registered-read memory and updated by one shared per-entry tick unit. After reset
// the block clears all KEY_COUNT entries in a pass before it takes its first item.
// Press, release and out-of-range or unused codes go from EXEC straight to DONE; a read
// of an in-range key passes through RDWAIT for the registered memory read, a tick walks
// the memory one entry per cycle with a registered write-back, and a clear rewrites
// every entry.
// Results leave through an output register, so a new item can be taken while a result
// waits for its transfer.
module key_repeat_tracker #(
	parameter int KEY_COUNT = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  op,
	input  wire logic [8:0]  key_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       key_flags,
	output logic [15:0]      held_frames,
	output logic             any_new_event,
	output logic             key_valid,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [9:0]  cfg_data
);

	localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
	localparam int CW = KW + 1;
	localparam logic [CW-1:0] LAST_IDX = CW'(KEY_COUNT - 1);
	localparam logic [CW-1:0] END_IDX  = CW'(KEY_COUNT);

	krt_pkg::state_t state_q, state_d;
	krt_pkg::cfg_t   cfg_q;

	logic [2:0]    op_q;
	logic [8:0]    key_q;
	logic [CW-1:0] idx_q;
	logic          p_valid_s1;
	logic [KW-1:0] p_addr_s1;
	logic          trig_q;

	logic [7:0]  res_flags_q;
	logic [15:0] res_frames_q;
	logic        res_event_q;
	logic        res_valid_q;

	logic        out_valid_q;
	logic [7:0]  out_flags_q;
	logic [15:0] out_frames_q;
	logic        out_event_q;
	logic        out_key_valid_q;

	logic            key_ok;
	logic            sweep_issue;
	logic            mem_we;
	logic [KW-1:0]   mem_waddr;
	krt_pkg::entry_t mem_wdata;
	logic            mem_re;
	logic [KW-1:0]   mem_raddr;
	krt_pkg::entry_t mem_rdata;
	krt_pkg::entry_t tick_nxt;
	logic            tick_trig;
	logic            out_free;

	assign key_ok      = {1'b0, key_q} < 10'(KEY_COUNT);
	assign sweep_issue = idx_q < END_IDX;
	assign out_free    = !out_valid_q || !out_stall;
	assign in_stall    = (state_q != krt_pkg::ST_IDLE);
	assign cfg_ready   = 1'b1;

	krt_mem #(
		.DEPTH(KEY_COUNT),
		.AW(KW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	krt_tick_unit u_tick (
		.cur(mem_rdata),
		.cfg(cfg_q),
		.nxt(tick_nxt),
		.trig(tick_trig)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= krt_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[KW-1:0];
		mem_wdata = krt_pkg::ENTRY_RESET;
		mem_re    = 1'b0;
		mem_raddr = key_q[KW-1:0];
		case (state_q)
			krt_pkg::ST_INIT, krt_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = (state_q == krt_pkg::ST_INIT) ? krt_pkg::ST_IDLE
						: krt_pkg::ST_DONE;
				end
			end
			krt_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = krt_pkg::ST_EXEC;
				end
			end
			krt_pkg::ST_EXEC: begin
				case (op_q)
					krt_pkg::OP_PRESS, krt_pkg::OP_RELEASE: begin
						mem_we    = key_ok;
						mem_waddr = key_q[KW-1:0];
						mem_wdata = '{flags: (op_q == krt_pkg::OP_PRESS)
							? krt_pkg::FLAGS_PRESS_EVT : krt_pkg::FLAGS_RELEASE_EVT,
							frames: 16'd0, slow: 8'd0, fast: 8'd0};
						state_d = krt_pkg::ST_DONE;
					end
					krt_pkg::OP_READ: begin
						mem_re  = key_ok;
						state_d = key_ok ? krt_pkg::ST_RDWAIT : krt_pkg::ST_DONE;
					end
					krt_pkg::OP_TICK: begin
						state_d = krt_pkg::ST_TICK;
					end
					krt_pkg::OP_CLEAR: begin
						state_d = krt_pkg::ST_CLEAR;
					end
					default: begin
						state_d = krt_pkg::ST_DONE;
					end
				endcase
			end
			krt_pkg::ST_RDWAIT: begin
				state_d = krt_pkg::ST_DONE;
			end
			krt_pkg::ST_TICK: begin
				mem_re    = sweep_issue;
				mem_raddr = idx_q[KW-1:0];
				mem_we    = p_valid_s1;
				mem_waddr = p_addr_s1;
				mem_wdata = tick_nxt;
				if (!sweep_issue && !p_valid_s1) begin
					state_d = krt_pkg::ST_DONE;
				end
			end
			krt_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = krt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = krt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_frames <= krt_pkg::START_FRAMES_RESET;
			cfg_q.slow_span    <= krt_pkg::SLOW_SPAN_RESET;
			cfg_q.fast_span    <= krt_pkg::FAST_SPAN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				krt_pkg::CFG_START_FRAMES: cfg_q.start_frames <= cfg_data;
				krt_pkg::CFG_SLOW_SPAN:    cfg_q.slow_span    <= cfg_data[7:0];
				krt_pkg::CFG_FAST_SPAN:    cfg_q.fast_span    <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			p_valid_s1  <= 1'b0;
			trig_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				krt_pkg::ST_INIT, krt_pkg::ST_CLEAR: idx_q <= idx_q + CW'(1);
				krt_pkg::ST_EXEC:                    idx_q <= '0;
				krt_pkg::ST_TICK: begin
					if (sweep_issue) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
			p_valid_s1 <= (state_q == krt_pkg::ST_TICK) && sweep_issue;
			if (state_q == krt_pkg::ST_EXEC) begin
				trig_q <= 1'b0;
			end else if (state_q == krt_pkg::ST_TICK && p_valid_s1 && tick_trig) begin
				trig_q <= 1'b1;
			end
			if (state_q == krt_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == krt_pkg::ST_IDLE && in_valid) begin
			op_q  <= op;
			key_q <= key_code;
		end
		p_addr_s1 <= idx_q[KW-1:0];
		case (state_q)
			krt_pkg::ST_EXEC: begin
				res_flags_q  <= 8'd0;
				res_frames_q <= 16'd0;
				res_event_q  <= 1'b0;
				res_valid_q  <= 1'b0;
				if (key_ok) begin
					if (op_q == krt_pkg::OP_PRESS) begin
						res_flags_q <= krt_pkg::FLAGS_PRESS_EVT;
						res_valid_q <= 1'b1;
					end else if (op_q == krt_pkg::OP_RELEASE) begin
						res_flags_q <= krt_pkg::FLAGS_RELEASE_EVT;
						res_valid_q <= 1'b1;
					end else if (op_q == krt_pkg::OP_READ) begin
						res_valid_q <= 1'b1;
					end
				end
			end
			krt_pkg::ST_RDWAIT: begin
				res_flags_q  <= mem_rdata.flags;
				res_frames_q <= mem_rdata.frames;
			end
			krt_pkg::ST_TICK: begin
				res_event_q <= trig_q;
			end
			default: begin
			end
		endcase
		if (state_q == krt_pkg::ST_DONE && out_free) begin
			out_flags_q     <= res_flags_q;
			out_frames_q    <= res_frames_q;
			out_event_q     <= res_event_q;
			out_key_valid_q <= res_valid_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign key_flags     = out_flags_q;
	assign held_frames   = out_frames_q;
	assign any_new_event = out_event_q;
	assign key_valid     = out_key_valid_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == krt_pkg::ST_DONE))
		else $error("result appeared without a finished item");

	a_pipe_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		p_valid_s1 |-> (state_q == krt_pkg::ST_TICK))
		else $error("tick write-back outside the sweep");

	a_sweep_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == krt_pkg::ST_TICK && p_valid_s1 && sweep_issue)
			|-> (p_addr_s1 != idx_q[KW-1:0]))
		else $error("sweep read and write-back hit the same entry");

	a_event_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_event_q) |-> (!out_key_valid_q && out_flags_q == 8'd0))
		else $error("tick result carries key data");

endmodule
`default_nettype wire

// File: verif/tb_key_repeat_tracker.sv
`default_nettype none
module tb_key_repeat_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KEYS = 256;
	localparam int HOLD_OFF_CYCLES = 600;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
	localparam logic [2:0] OP_LAST_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0]  flags;
		logic [15:0] frames;
		logic        new_event;
		logic        in_range;
	} key_report_t;

	class repeat_scoreboard;
		logic [7:0]  key_flags_tab [KEYS];
		logic [15:0] frame_tab [KEYS];
		logic [7:0]  slow_cd [KEYS];
		logic [7:0]  fast_cd [KEYS];
		logic        trigger_seen;
		logic [9:0]  start_frames;
		logic [7:0]  slow_span;
		logic [7:0]  fast_span;
		key_report_t due_key_reports [$];
		int          mismatches;

		function new();
			start_frames = krt_pkg::START_FRAMES_RESET;
			slow_span = krt_pkg::SLOW_SPAN_RESET;
			fast_span = krt_pkg::FAST_SPAN_RESET;
			trigger_seen = 1'b0;
			mismatches = 0;
			wipe_table();
		endfunction

		function void wipe_table();
			for (int k = 0; k < KEYS; k++) begin
				key_flags_tab[k] = krt_pkg::FL_FREE;
				frame_tab[k] = '0;
				slow_cd[k] = '0;
				fast_cd[k] = '0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [9:0] val);
			case (idx)
				krt_pkg::CFG_START_FRAMES: start_frames = val;
				krt_pkg::CFG_SLOW_SPAN: slow_span = val[7:0];
				krt_pkg::CFG_FAST_SPAN: fast_span = val[7:0];
				default: ;
			endcase
		endfunction

		function logic tick_sweep();
			logic       trig;
			logic       level;
			logic [7:0] f;
			logic [7:0] rep_bit;
			logic [7:0] fast_bit;
			trig = 1'b0;
			for (int k = 0; k < KEYS; k++) begin
				if (frame_tab[k] != 16'd0) begin
					f = key_flags_tab[k];
					level = 1'b1;
					rep_bit = '0;
					fast_bit = '0;
					if ((f & krt_pkg::FL_PRESS) != 8'd0) begin
						f = krt_pkg::FL_PRESS;
						rep_bit = krt_pkg::FL_PRESS_REP;
						fast_bit = krt_pkg::FL_PRESS_FAST;
					end else if ((f & krt_pkg::FL_FREE) != 8'd0) begin
						f = krt_pkg::FL_FREE;
						rep_bit = krt_pkg::FL_FREE_REP;
						fast_bit = krt_pkg::FL_FREE_FAST;
					end else begin
						level = 1'b0;
					end
					if (level && frame_tab[k] >= {6'd0, start_frames}) begin
						if (slow_cd[k] == 8'd0) begin
							slow_cd[k] = slow_span;
							f = f | rep_bit;
						end else begin
							slow_cd[k] = slow_cd[k] - 8'd1;
						end
						if (fast_cd[k] == 8'd0) begin
							fast_cd[k] = fast_span;
							f = f | fast_bit;
						end else begin
							fast_cd[k] = fast_cd[k] - 8'd1;
						end
					end
					key_flags_tab[k] = f;
				end else begin
					trig = 1'b1;
				end
				if (frame_tab[k] != 16'hFFFF)
					frame_tab[k] = frame_tab[k] + 16'd1;
			end
			return trig;
		endfunction

		function void note_item(logic [2:0] o, logic [8:0] k);
			key_report_t r;
			logic        ok;
			r = '0;
			ok = (k < KEYS);
			case (o)
				krt_pkg::OP_PRESS, krt_pkg::OP_RELEASE: begin
					if (ok) begin
						key_flags_tab[k] = (o == krt_pkg::OP_PRESS)
							? krt_pkg::FLAGS_PRESS_EVT : krt_pkg::FLAGS_RELEASE_EVT;
						frame_tab[k] = '0;
						slow_cd[k] = '0;
						fast_cd[k] = '0;
						r.flags = key_flags_tab[k];
						r.in_range = 1'b1;
					end
				end
				krt_pkg::OP_TICK: begin
					trigger_seen = tick_sweep();
					r.new_event = trigger_seen;
				end
				krt_pkg::OP_READ: begin
					if (ok) begin
						r.flags = key_flags_tab[k];
						r.frames = frame_tab[k];
						r.in_range = 1'b1;
					end
				end
				krt_pkg::OP_CLEAR: wipe_table();
				default: ;
			endcase
			due_key_reports.push_back(r);
		endfunction

		function void check_result(key_report_t got);
			key_report_t want;
			if (due_key_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: transfer out with no report due: ",
						"flags %h frames %0d event %b valid %b"},
						$time, got.flags, got.frames, got.new_event, got.in_range);
				return;
			end
			want = due_key_reports.pop_front();
			if (want.flags !== got.flags || want.frames !== got.frames ||
					want.new_event !== got.new_event || want.in_range !== got.in_range) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: report differs (exp/got): flags %h/%h ",
						"frames %0d/%0d event %b/%b valid %b/%b"},
						$time, want.flags, got.flags, want.frames, got.frames,
						want.new_event, got.new_event, want.in_range, got.in_range);
			end
		endfunction

		function int pending();
			return due_key_reports.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [8:0]  key_code;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  key_flags;
	logic [15:0] held_frames;
	logic        any_new_event;
	logic        key_valid;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;

	repeat_scoreboard sb;
	int          items_sent = 0;
	int          cur_start = krt_pkg::START_FRAMES_RESET;
	int          hold_off_asked = 0;
	int          hold_off_done = 0;
	int unsigned cycle_count = 0;
	logic [8:0]  hot_keys [8];

	key_repeat_tracker #(.KEY_COUNT(KEYS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.key_code(key_code),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_flags(key_flags),
		.held_frames(held_frames),
		.any_new_event(any_new_event),
		.key_valid(key_valid),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && !in_stall)
				sb.note_item(op, key_code);
			if (out_valid && !out_stall)
				sb.check_result('{flags: key_flags, frames: held_frames,
					new_event: any_new_event, in_range: key_valid});
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [8:0] rand9();
		return 9'($urandom_range(0, 511));
	endfunction

	function automatic logic [8:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return hot_keys[$urandom_range(0, 7)];
		if (r < 90)
			return 9'($urandom_range(0, KEYS - 1));
		return 9'($urandom_range(KEYS, 511));
	endfunction

	initial begin
		int run;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_done != hold_off_asked) begin
				hold_off_done++;
				out_stall <= 1'b1;
				run = HOLD_OFF_CYCLES;
			end else if ($urandom_range(0, 99) < 35) begin
				out_stall <= 1'b1;
				run = pick_gap() + 1;
			end else begin
				out_stall <= 1'b0;
				run = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
			end
			repeat (run) @(posedge clk);
		end
	end

	task automatic send_item(input logic [2:0] o, input logic [8:0] k);
		int gap;
		in_valid <= 1'b1;
		op <= o;
		key_code <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic run_random(input int n);
		int         stop_at;
		int         r;
		int         ticks;
		logic [8:0] k;
		stop_at = items_sent + n;
		hold_off_asked++;
		while (items_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				// Event on a key, then a random run of ticks that may carry it into its repeat window.
				k = hot_keys[$urandom_range(0, 7)];
				send_item(($urandom_range(0, 1) == 0) ? krt_pkg::OP_PRESS
					: krt_pkg::OP_RELEASE, k);
				ticks = $urandom_range(1, (cur_start < 12) ? cur_start + 4 : 16);
				repeat (ticks) begin
					send_item(krt_pkg::OP_TICK, rand9());
					if ($urandom_range(0, 3) == 0)
						send_item(krt_pkg::OP_READ, k);
				end
				send_item(krt_pkg::OP_READ, k);
			end else if (r < 48) begin
				send_item(krt_pkg::OP_TICK, rand9());
			end else if (r < 68) begin
				send_item(krt_pkg::OP_READ, pick_key());
			end else if (r < 80) begin
				send_item(krt_pkg::OP_PRESS, pick_key());
			end else if (r < 92) begin
				send_item(krt_pkg::OP_RELEASE, pick_key());
			end else if (r < 96) begin
				send_item(krt_pkg::OP_CLEAR, rand9());
			end else begin
				send_item(3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED)), pick_key());
			end
		end
	endtask

	task automatic run_phase(input int start, input int slow, input int fast, input int n);
		settle_idle();
		write_reg(krt_pkg::CFG_START_FRAMES, 10'(start));
		write_reg(krt_pkg::CFG_SLOW_SPAN, 10'(slow));
		write_reg(krt_pkg::CFG_FAST_SPAN, 10'(fast));
		cur_start = start;
		foreach (hot_keys[i])
			hot_keys[i] = 9'($urandom_range(0, KEYS - 1));
		run_random(n);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = krt_pkg::OP_PRESS;
		key_code = '0;
		cfg_valid = 1'b0;
		cfg_index = krt_pkg::CFG_START_FRAMES;
		cfg_data = '0;
		sb = new();
		foreach (hot_keys[i])
			hot_keys[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(krt_pkg::OP_TICK, 9'd0);
		send_item(krt_pkg::OP_TICK, 9'd511);
		send_item(krt_pkg::OP_READ, 9'd0);
		send_item(krt_pkg::OP_PRESS, 9'd0);
		send_item(krt_pkg::OP_RELEASE, 9'd255);
		send_item(krt_pkg::OP_PRESS, 9'd255);
		send_item(krt_pkg::OP_READ, 9'd255);
		send_item(krt_pkg::OP_READ, 9'd0);
		send_item(krt_pkg::OP_PRESS, 9'd256);
		send_item(krt_pkg::OP_RELEASE, 9'd511);
		send_item(krt_pkg::OP_READ, 9'd300);
		send_item(krt_pkg::OP_READ, 9'd511);
		send_item(OP_FIRST_UNUSED, 9'd0);
		send_item(OP_FIRST_UNUSED + 3'd1, 9'd128);
		send_item(OP_LAST_UNUSED, 9'd511);
		send_item(krt_pkg::OP_TICK, 9'd0);
		send_item(krt_pkg::OP_TICK, 9'd0);
		send_item(krt_pkg::OP_READ, 9'd0);
		send_item(krt_pkg::OP_CLEAR, 9'd0);
		send_item(krt_pkg::OP_READ, 9'd0);
		send_item(krt_pkg::OP_TICK, 9'd0);
		send_item(krt_pkg::OP_READ, 9'd128);

		run_phase(0, 0, 0, 250);
		run_phase(1023, 255, 255, 120);
		run_phase(4, 3, 1, 300);
		run_phase(12, 8, 2, 250);
		run_phase(1, 255, 0, 230);

		settle_idle();
		repeat (KEYS + 40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
